FILE: hdl/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int MAX_QUERY_LEN_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QLEN_W     = 6;
    localparam int SCORE_W    = 10;
    localparam int COUNT_W    = 6;
    localparam int POS_W      = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WORD_0 = 3'd1;

    localparam logic [SCORE_W-1:0] SCORE_START = 10'd100;
    localparam logic [SCORE_W-1:0] BONUS_SEQ   = 10'd15;
    localparam logic [SCORE_W-1:0] BONUS_SEP   = 10'd10;
    localparam logic [SCORE_W-1:0] BONUS_CAMEL = 10'd10;
    localparam logic [SCORE_W-1:0] BONUS_FIRST = 10'd15;
    localparam logic [COUNT_W-1:0] LEN_CAP     = 6'd50;
    localparam logic [COUNT_W-1:0] POS_CAP     = 6'd10;

    typedef struct packed {
        logic [7:0] text_char;
        logic       no_char;
        logic       last_item;
    } text_item_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        return is_upper(c) ? (c + 8'h20) : c;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h2F) || (c == 8'h5C) || (c == 8'h5F) ||
               (c == 8'h2D) || (c == 8'h2E) || (c == 8'h3A);
    endfunction

endpackage

FILE: hdl/fsc_ifs.sv
`timescale 1ns / 1ps

interface fsc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       no_char;
    logic       last_item;

    modport source (output valid, output text_char, output no_char, output last_item,
                    input ready);
    modport sink (input valid, input text_char, input no_char, input last_item,
                  output ready);
endinterface

interface fsc_result_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [9:0] score;

    modport source (output valid, output matched, output score, input ready);
    modport sink (input valid, input matched, input score, output ready);
endinterface

FILE: hdl/fuzzy_subsequence_scorer_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake      word
// text      in   valid/ready    text_char[7:0], no_char, last_item
// result    out  valid/ready    matched, score[9:0]
// cfg       in   cfg_write_en   cfg_index[2:0], cfg_data[63:0]
//
// one text word per cycle unless a last word waits behind a held result; a word is
// held in the input register, and the byte compare, bonus add and state update work from it
// the result register is loaded when its last word leaves the input register
// reset clears per-text state, the result valid flag and the query registers
// a last word waits in the input register only while an earlier result is held

module fuzzy_subsequence_scorer_unit #(
    parameter int MAX_QUERY_LEN = fsc_pkg::MAX_QUERY_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data,
    fsc_text_if.sink                       text,
    fsc_result_if.source                   result
);

    localparam int QIDX_W = $clog2(MAX_QUERY_LEN + 1);

    logic [QIDX_W-1:0]             qlen;
    logic [MAX_QUERY_LEN-1:0][7:0] query_bytes;
    logic                          item_valid;
    fsc_pkg::text_item_t           item;
    logic                          advance;

    fsc_cfg_regs #(
        .MAX_QUERY_LEN (MAX_QUERY_LEN),
        .QIDX_W        (QIDX_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .qlen         (qlen),
        .query_bytes  (query_bytes)
    );

    fsc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fsc_score_core #(
        .MAX_QUERY_LEN (MAX_QUERY_LEN),
        .QIDX_W        (QIDX_W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .qlen        (qlen),
        .query_bytes (query_bytes),
        .item_valid  (item_valid),
        .item        (item),
        .advance     (advance),
        .result      (result)
    );

endmodule

FILE: hdl/fsc_cfg_regs.sv
`timescale 1ns / 1ps

module fsc_cfg_regs #(
    parameter int MAX_QUERY_LEN = fsc_pkg::MAX_QUERY_LEN_DEF,
    parameter int QIDX_W        = $clog2(MAX_QUERY_LEN + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [QIDX_W-1:0]                 qlen,
    output logic [MAX_QUERY_LEN-1:0][7:0]     query_bytes
);

    logic [fsc_pkg::QLEN_W-1:0]          query_length_reg;
    logic [MAX_QUERY_LEN-1:0][7:0]       query_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            query_reg        <= '0;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == fsc_pkg::CFG_QUERY_LENGTH)
            begin
                query_length_reg <= cfg_data[fsc_pkg::QLEN_W-1:0];
            end
            // only the bytes that can ever be reached are kept
            for (int k = 0; k < MAX_QUERY_LEN; k++)
            begin
                if (cfg_index == fsc_pkg::CFG_IDX_W'(fsc_pkg::CFG_QUERY_WORD_0 + (k >> 3)))
                begin
                    query_reg[k] <= cfg_data[8 * (k & 7) +: 8];
                end
            end
        end
    end

    // lengths above the storage are clamped
    assign qlen = (query_length_reg > fsc_pkg::QLEN_W'(MAX_QUERY_LEN))
                ? QIDX_W'(MAX_QUERY_LEN) : QIDX_W'(query_length_reg);
    assign query_bytes = query_reg;

endmodule

FILE: hdl/fsc_in_stage.sv
`timescale 1ns / 1ps

module fsc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    fsc_text_if.sink            text,
    input  logic                advance,
    output logic                item_valid,
    output fsc_pkg::text_item_t item
);

    logic                valid_reg;
    fsc_pkg::text_item_t item_reg;
    logic                take;

    assign text.ready = !valid_reg || advance;
    assign take       = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{text_char: text.text_char, no_char: text.no_char,
                          last_item: text.last_item};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/fsc_score_core.sv
`timescale 1ns / 1ps

module fsc_score_core #(
    parameter int MAX_QUERY_LEN = fsc_pkg::MAX_QUERY_LEN_DEF,
    parameter int QIDX_W        = $clog2(MAX_QUERY_LEN + 1),
    parameter int SEL_W         = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [QIDX_W-1:0]             qlen,
    input  logic [MAX_QUERY_LEN-1:0][7:0] query_bytes,
    input  logic                          item_valid,
    input  fsc_pkg::text_item_t           item,
    output logic                          advance,
    fsc_result_if.source                  result
);

    logic [QIDX_W-1:0]                   query_index_reg, query_index_next;
    logic [fsc_pkg::COUNT_W-1:0]         text_count_reg, text_count_next;
    logic [fsc_pkg::POS_W-1:0]           first_pos_reg, first_pos_next;
    logic                                first_seen_reg, first_seen_next;
    logic [7:0]                          prev_char_reg, prev_char_next;
    logic                                prev_matched_reg, prev_matched_next;
    logic [fsc_pkg::SCORE_W-1:0]         running_score_reg, running_score_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                matched_reg, matched_next;
    logic [fsc_pkg::SCORE_W-1:0]         score_reg, score_next;

    logic                                fire;
    logic                                active;
    logic                                hit;
    logic [7:0]                          qc;
    logic [fsc_pkg::SCORE_W-1:0]         bonus;

    // a last word waits only while the result register is still full
    assign advance = !item.last_item || !out_valid_reg || result.ready;
    assign fire    = item_valid && advance;

    assign qc     = query_bytes[query_index_reg[SEL_W-1:0]];
    assign active = !item.no_char && (query_index_reg < qlen);
    assign hit    = active && (fsc_pkg::fold_char(item.text_char) == fsc_pkg::fold_char(qc));

    always_comb
    begin
        bonus = '0;
        priority if (text_count_reg == '0)
        begin
            bonus = fsc_pkg::BONUS_FIRST;
        end
        else if (fsc_pkg::is_sep(prev_char_reg))
        begin
            bonus = fsc_pkg::BONUS_SEP;
        end
        else if (fsc_pkg::is_lower(prev_char_reg) && fsc_pkg::is_upper(item.text_char))
        begin
            bonus = fsc_pkg::BONUS_CAMEL;
        end
        else
        begin
            bonus = '0;
        end
        if (prev_matched_reg)
        begin
            bonus = bonus + fsc_pkg::BONUS_SEQ;
        end
    end

    always_comb
    begin
        query_index_next   = query_index_reg;
        text_count_next    = text_count_reg;
        first_pos_next     = first_pos_reg;
        first_seen_next    = first_seen_reg;
        prev_char_next     = prev_char_reg;
        prev_matched_next  = prev_matched_reg;
        running_score_next = running_score_reg;

        if (!item.no_char)
        begin
            prev_char_next = item.text_char;
            if (text_count_reg < fsc_pkg::LEN_CAP)
            begin
                text_count_next = text_count_reg + 1'b1;
            end
            if (active && !hit)
            begin
                prev_matched_next = 1'b0;
            end
            if (hit)
            begin
                prev_matched_next  = 1'b1;
                query_index_next   = query_index_reg + 1'b1;
                running_score_next = running_score_reg + bonus;
                if (!first_seen_reg)
                begin
                    first_seen_next = 1'b1;
                    first_pos_next  = (text_count_reg > fsc_pkg::POS_CAP)
                                    ? fsc_pkg::POS_W'(fsc_pkg::POS_CAP)
                                    : text_count_reg[fsc_pkg::POS_W-1:0];
                end
            end
        end
    end

    // result from the state as it stands after this word
    always_comb
    begin
        matched_next = 1'b0;
        score_next   = '0;
        priority if (qlen == '0)
        begin
            matched_next = 1'b1;
        end
        else if ((text_count_next == '0) || (query_index_next != qlen))
        begin
            matched_next = 1'b0;
        end
        else
        begin
            matched_next = 1'b1;
            score_next   = running_score_next
                         - fsc_pkg::SCORE_W'(first_pos_next)
                         - fsc_pkg::SCORE_W'(text_count_next);
        end
    end

    assign out_valid_next = (fire && item.last_item) ? 1'b1
                          : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_index_reg   <= '0;
            text_count_reg    <= '0;
            first_pos_reg     <= '0;
            first_seen_reg    <= 1'b0;
            prev_char_reg     <= '0;
            prev_matched_reg  <= 1'b0;
            running_score_reg <= fsc_pkg::SCORE_START;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                if (item.last_item)
                begin
                    query_index_reg   <= '0;
                    text_count_reg    <= '0;
                    first_pos_reg     <= '0;
                    first_seen_reg    <= 1'b0;
                    prev_char_reg     <= '0;
                    prev_matched_reg  <= 1'b0;
                    running_score_reg <= fsc_pkg::SCORE_START;
                end
                else
                begin
                    query_index_reg   <= query_index_next;
                    text_count_reg    <= text_count_next;
                    first_pos_reg     <= first_pos_next;
                    first_seen_reg    <= first_seen_next;
                    prev_char_reg     <= prev_char_next;
                    prev_matched_reg  <= prev_matched_next;
                    running_score_reg <= running_score_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.last_item)
        begin
            matched_reg <= matched_next;
            score_reg   <= score_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;
    assign result.score   = score_reg;

endmodule

FILE: hdl/fsc_checker.sv
`timescale 1ns / 1ps

module fsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       matched,
    input logic [9:0] score
);

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(score))
        else $error("result changed while stalled");

    // a fresh result is preceded by a text word taken on the text channel
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding text word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> score == 10'd0)
        else $error("score on a failed match");

    // non-zero scores lie between the floor and ceiling of the bonus scheme
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched && (score != 10'd0) |-> (score >= 10'd40) && (score <= 10'd890))
        else $error("score out of range");

endmodule

bind fuzzy_subsequence_scorer_unit fsc_checker u_fsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .matched   (result.matched),
    .score     (result.score)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit                          matched;
        logic [fsc_pkg::SCORE_W-1:0] score;
    } score_t;

    localparam int N_WORDS      = 4;
    localparam int RANDOM_ITEMS = 1500;

    // indexes past the query words hold no register
    localparam logic [fsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        fsc_pkg::CFG_QUERY_WORD_0 + fsc_pkg::CFG_IDX_W'(N_WORDS);
    localparam logic [fsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    localparam logic [6:0][7:0] BREAK_CHARS = {8'h20, 8'h2F, 8'h5C, 8'h5F, 8'h2D, 8'h2E, 8'h3A};

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data;

    fsc_text_if   text_ch ();
    fsc_result_if result_ch ();

    fuzzy_subsequence_scorer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text         (text_ch),
        .result       (result_ch)
    );

    // scorer state as the testbench sees it
    logic [fsc_pkg::QLEN_W-1:0]                   q_len;
    logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0]  q_word;
    int unsigned                                  q_pos;
    int unsigned                                  text_len;
    int unsigned                                  first_at;
    bit                                           first_hit;
    bit                                           prev_hit;
    logic [7:0]                                   prev_byte;
    logic [fsc_pkg::SCORE_W-1:0]                  tally;

    score_t pending_scores[$];
    int     n_errors   = 0;
    int     bytes_sent = 0;
    int     gap_max    = 0;
    int     stall_max  = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic bit is_break(input logic [7:0] c);
        for (int i = 0; i < $size(BREAK_CHARS); i++)
        begin
            if (BREAK_CHARS[i] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned active_len();
        return (q_len > fsc_pkg::MAX_QUERY_LEN_DEF) ? fsc_pkg::MAX_QUERY_LEN_DEF : int'(q_len);
    endfunction

    function automatic logic [7:0] query_byte(input int unsigned k);
        return q_word[k / 8][8 * (k % 8) +: 8];
    endfunction

    function automatic void clear_text();
        q_pos     = 0;
        text_len  = 0;
        first_at  = 0;
        first_hit = 1'b0;
        prev_hit  = 1'b0;
        prev_byte = '0;
        tally     = fsc_pkg::SCORE_START;
    endfunction

    // advance the scorer by one accepted word, queue the score on the last one
    function automatic void score_word(input fsc_pkg::text_item_t w);
        int unsigned qn;
        score_t      res;
        qn = active_len();
        if (!w.no_char)
        begin
            if (q_pos < qn)
            begin
                if (to_lower(w.text_char) != to_lower(query_byte(q_pos)))
                    prev_hit = 1'b0;
                else
                begin
                    if (!first_hit)
                    begin
                        first_hit = 1'b1;
                        first_at  = (text_len > fsc_pkg::POS_CAP) ? fsc_pkg::POS_CAP : text_len;
                    end
                    if (text_len == 0)
                        tally += fsc_pkg::BONUS_FIRST;
                    else if (is_break(prev_byte))
                        tally += fsc_pkg::BONUS_SEP;
                    else if (prev_byte >= 8'h61 && prev_byte <= 8'h7A &&
                             w.text_char >= 8'h41 && w.text_char <= 8'h5A)
                        tally += fsc_pkg::BONUS_CAMEL;
                    if (prev_hit)
                        tally += fsc_pkg::BONUS_SEQ;
                    prev_hit = 1'b1;
                    q_pos++;
                end
            end
            prev_byte = w.text_char;
            if (text_len < fsc_pkg::LEN_CAP)
                text_len++;
        end
        if (w.last_item)
        begin
            res.score = '0;
            if (qn == 0)
                res.matched = 1'b1;
            else if (text_len == 0 || q_pos != qn)
                res.matched = 1'b0;
            else
            begin
                res.matched = 1'b1;
                res.score   = tally - fsc_pkg::SCORE_W'(first_at)
                                    - fsc_pkg::SCORE_W'(text_len);
            end
            pending_scores.push_back(res);
            clear_text();
        end
    endfunction

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
            3, 4:    return 8'(8'h41 + $urandom_range(0, 25));
            5:       return BREAK_CHARS[$urandom_range(0, $size(BREAK_CHARS) - 1)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(input logic [7:0] c, input bit blank, input bit last);
        int                  gap;
        fsc_pkg::text_item_t w;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_char <= c;
        text_ch.no_char   <= blank;
        text_ch.last_item <= last;
        do @(posedge clk); while (!text_ch.ready);
        w.text_char = c;
        w.no_char   = blank;
        w.last_item = last;
        score_word(w);
        if (!blank)
            bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0, i == s.len() - 1);
    endtask

    // hold the sender until every score is back and the pipeline is empty
    task automatic drain();
        text_ch.valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // which[0] selects the length, which[1+w] query word w
    task automatic program_query(input logic [fsc_pkg::QLEN_W-1:0]                  len,
                                 input logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] words,
                                 input logic [N_WORDS:0]                            which,
                                 input bit                                          spare);
        drain();
        for (int i = 0; i <= N_WORDS; i++)
        begin
            if (which[i])
            begin
                cfg_write_en <= 1'b1;
                if (i == 0)
                begin
                    cfg_index <= fsc_pkg::CFG_QUERY_LENGTH;
                    cfg_data  <= fsc_pkg::CFG_DATA_W'({$urandom, $urandom, len});
                end
                else
                begin
                    cfg_index <= fsc_pkg::CFG_QUERY_WORD_0 + fsc_pkg::CFG_IDX_W'(i - 1);
                    cfg_data  <= words[i - 1];
                end
                @(posedge clk);
                if (i == 0)
                    q_len = len;
                else
                    q_word[i - 1] = words[i - 1];
            end
        end
        if (spare)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= fsc_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
            cfg_data     <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_query(input string q);
        logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] qw;
        qw = '0;
        for (int k = 0; k < q.len(); k++)
            qw[k / 8][8 * (k % 8) +: 8] = q[k];
        program_query(fsc_pkg::QLEN_W'(q.len()), qw, '1, 1'b0);
    endtask

    task automatic test_empty_query();
        logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] qw;
        send_text("abc");
        send_word(8'h00, 1'b1, 1'b1);
        qw = '1;
        program_query('0, qw, '1, 1'b0);
        send_text("x");
    endtask

    task automatic test_basic_scoring();
        set_query("ab");
        send_text("ab");
        send_text("x-aB");
        send_word(8'h61, 1'b1, 1'b1);
        send_text("zzb");
        // blank words in the middle and at the end leave the score alone
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'h62, 1'b0, 1'b0);
        send_word(8'h71, 1'b1, 1'b1);
        send_text("Abxyz");
    endtask

    task automatic test_limits();
        logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] qw;
        // oversized length folds to the full query, position and length both saturate
        qw = '1;
        program_query('1, qw, '1, 1'b0);
        repeat (12) send_word(8'h00, 1'b0, 1'b0);
        repeat (fsc_pkg::MAX_QUERY_LEN_DEF) send_word(8'hFF, 1'b0, 1'b0);
        repeat (7) send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h3A, 1'b0, 1'b1);
        qw = '0;
        program_query(fsc_pkg::QLEN_W'(1), qw, '1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_spare_registers();
        logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] qw;
        qw = '1;
        repeat (3) program_query('0, qw, '0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h41, 1'b0, 1'b1);
    endtask

    task automatic random_query(input int phase);
        logic [N_WORDS-1:0][fsc_pkg::CFG_DATA_W-1:0] qw;
        logic [fsc_pkg::QLEN_W-1:0]                  len;
        logic [N_WORDS:0]                            which;
        int                                          pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = fsc_pkg::QLEN_W'(fsc_pkg::MAX_QUERY_LEN_DEF);
        else if (pick == 2)
            len = fsc_pkg::QLEN_W'($urandom_range(fsc_pkg::MAX_QUERY_LEN_DEF + 1,
                                                  (1 << fsc_pkg::QLEN_W) - 1));
        else
            len = fsc_pkg::QLEN_W'($urandom_range(1, 8));
        for (int k = 0; k < N_WORDS * 8; k++)
            qw[k / 8][8 * (k % 8) +: 8] = random_char();
        if (phase == 0 || $urandom_range(0, 1))
            which = '1;
        else
            which = (N_WORDS + 1)'($urandom);
        program_query(len, qw, which, $urandom_range(0, 3) == 0);
    endtask

    task automatic random_text();
        logic [7:0]  txt[$];
        logic [7:0]  c;
        int unsigned qn;
        int          shape;
        int          fill;
        int          drop;
        bit          tail_blank;
        qn    = active_len();
        shape = $urandom_range(0, 15);
        drop  = -1;
        if (shape == 0)
        begin
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            return;
        end
        if (shape <= 2 || qn == 0)
        begin
            repeat ($urandom_range(1, 12)) txt.push_back(random_char());
        end
        else
        begin
            // query spread through filler, sometimes with a letter left out
            if (shape == 3)
                drop = $urandom_range(0, qn - 1);
            for (int k = 0; k < qn; k++)
            begin
                fill = $urandom_range(0, 1) ? 0 : $urandom_range(1, (shape == 4) ? 20 : 3);
                repeat (fill) txt.push_back(random_char());
                c = query_byte(k);
                if ($urandom_range(0, 1))
                begin
                    if (c >= 8'h41 && c <= 8'h5A)
                        c += 8'h20;
                    else if (c >= 8'h61 && c <= 8'h7A)
                        c -= 8'h20;
                end
                if (k != drop)
                    txt.push_back(c);
            end
            repeat ($urandom_range(0, 4)) txt.push_back(random_char());
        end
        if (txt.size() == 0)
            txt.push_back(random_char());
        tail_blank = $urandom_range(0, 7) == 0;
        foreach (txt[i])
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_word(txt[i], 1'b0, !tail_blank && i == txt.size() - 1);
        end
        if (tail_blank)
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic test_random_texts();
        int phase;
        phase      = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0:       begin gap_max = 7; stall_max = 7; end
                1:       begin gap_max = 0; stall_max = 0; end
                2:       begin gap_max = 7; stall_max = 0; end
                default: begin gap_max = 0; stall_max = 7; end
            endcase
            random_query(phase);
            repeat ($urandom_range(10, 40)) random_text();
            phase++;
        end
    endtask

    initial
    begin : result_check
        score_t want;
        int     stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                do @(posedge clk); while (!result_ch.valid);
                repeat (stall - 1) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (pending_scores.size() == 0)
            begin
                $error("unexpected result word: matched %0b score %0d",
                       result_ch.matched, result_ch.score);
                n_errors++;
            end
            else
            begin
                want = pending_scores.pop_front();
                if (result_ch.matched !== want.matched)
                begin
                    $error("matched: expected %0b, got %0b", want.matched, result_ch.matched);
                    n_errors++;
                end
                if (result_ch.score !== want.score)
                begin
                    $error("score: expected %0d, got %0d", want.score, result_ch.score);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[fuzzy_subsequence_scorer_unit] ERROR");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_write_en      <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        text_ch.valid     <= 1'b0;
        text_ch.text_char <= '0;
        text_ch.no_char   <= 1'b0;
        text_ch.last_item <= 1'b0;
        q_len  = '0;
        q_word = '0;
        clear_text();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_query();
        test_basic_scoring();
        test_limits();
        test_spare_registers();
        test_random_texts();
        drain();
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("[fuzzy_subsequence_scorer_unit] OK");
        else
            $display("[fuzzy_subsequence_scorer_unit] ERROR");
        $finish;
    end

endmodule
